/* hdl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the maze carver RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define RMC_ASSERT(lbl, clk_s, rst_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) prop) else $error(msg);

// Condition must never be seen at a clock edge outside reset.
`define RMC_NEVER(lbl, clk_s, rst_s, cond, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) !(cond)) else $error(msg);

`endif

/* hdl/rmc_pkg.sv */
// ----------------------------------------------------------------------------
// rmc_pkg
// Types, codes and constants of the random maze carver.
// ----------------------------------------------------------------------------
package rmc_pkg;

  localparam int DEF_MAX_ROWS = 32;
  localparam int DEF_MAX_COLS = 128;

  // grid dimension arithmetic: holds 0..256 and every 6/8-bit pick field
  localparam int DIM_W    = 9;
  localparam int ADDR_W   = 4;
  localparam int STATUS_W = 2;

  localparam logic [6:0] DRAW_RIGHT_BELOW = 7'd25;
  localparam logic [6:0] DRAW_LEFT_BELOW  = 7'd50;
  localparam logic [6:0] DRAW_DOWN_BELOW  = 7'd75;

  localparam logic [1:0] REG_ROWS = 2'd0;
  localparam logic [1:0] REG_COLS = 2'd1;
  localparam logic [1:0] REG_WALK = 2'd2;

  localparam logic FUNC_START = 1'b0;

  typedef enum logic [STATUS_W-1:0] {
    ST_STARTED  = 2'd0,
    ST_CARVED   = 2'd1,
    ST_REJECTED = 2'd2,
    ST_FULL     = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    DIR_RIGHT = 2'd0,
    DIR_LEFT  = 2'd1,
    DIR_DOWN  = 2'd2,
    DIR_UP    = 2'd3
  } dir_t;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_READ = 4'b0010,
    S_EVAL = 4'b0100,
    S_FIN  = 4'b1000
  } state_t;

  function automatic dir_t draw_to_dir(input logic [6:0] draw);
    if (draw < DRAW_RIGHT_BELOW) return DIR_RIGHT;
    else if (draw < DRAW_LEFT_BELOW) return DIR_LEFT;
    else if (draw < DRAW_DOWN_BELOW) return DIR_DOWN;
    else return DIR_UP;
  endfunction

endpackage

/* hdl/random_maze_carver.sv */
// ----------------------------------------------------------------------------
// random_maze_carver
// Grows a random spanning-tree maze, at most one carve per transaction.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream: s_tuser = func (0 start a new maze, 1 try one carve),
//   s_tdata = pick row, pick column, direction draw. Output stream: one
//   transaction per input, m_tuser = status, m_tdata = opened wall and the
//   complete flag. Grid size and walk mode come over the APB port; the user
//   must change them only while the block is idle, which the block does not enforce.
//   The visited map sits in a row-wide synchronous RAM (one row of columns per
//   word, one read port, bit-masked write) with a valid flop per row, so a
//   start clears the whole map when it is accepted and there is no clearing pass.
//   Sequence from accept to m_tvalid (s_tready returns in the same cycle as m_tvalid):
//     start, finished maze or a pick outside the grid: accept, then the result state;
//     attempt: accept, three row reads plus the read latency, the evaluate
//       state with the write-back, then the result state;
//     walk mode with a stuck current cell: a second read sweep and evaluate
//       around the pick before the result state.
//   One item is in flight at a time; the single read port makes the row reads sequential.
//   Reset: map cleared, count zero, registers 9 / 9 / 0; an attempt before a
//   start answers "already complete".
//   Stall: the result waits in the output register; the block holds its
//   result cycle until the register drains, and does not accept meanwhile.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module random_maze_carver #(
  parameter int MAX_ROWS = rmc_pkg::DEF_MAX_ROWS,
  parameter int MAX_COLS = rmc_pkg::DEF_MAX_COLS
) (
  input  logic                          clk,
  input  logic                          rst,
  // input stream
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [23:0]                   s_tdata,   // pick_row[5:0], pick_col[13:6], dir_draw[20:14]
  input  logic                          s_tuser,   // func
  // output stream
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [23:0]                   m_tdata,   // from_row[5:0], from_col[13:6],
                                                   // carve_dir[15:14], complete[16]
  output logic [rmc_pkg::STATUS_W-1:0]  m_tuser,   // status
  // configuration
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [rmc_pkg::ADDR_W-1:0]    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import rmc_pkg::*;

  localparam int ROW_AW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int COL_AW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int CNT_W  = (MAX_ROWS * MAX_COLS > 1) ? $clog2(MAX_ROWS * MAX_COLS) : 1;

  // --------------------------------------------------------------------------
  // configuration registers
  // --------------------------------------------------------------------------
  logic [5:0] row_count;
  logic [7:0] col_count;
  logic       walk_mode;
  logic       cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_count <= 6'd9;
      col_count <= 8'd9;
      walk_mode <= 1'b0;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_ROWS: row_count <= pwdata[5:0];
        REG_COLS: col_count <= pwdata[7:0];
        REG_WALK: walk_mode <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_ROWS: prdata = 32'(row_count);
      REG_COLS: prdata = 32'(col_count);
      REG_WALK: prdata = 32'(walk_mode);
      default:  prdata = 32'd0;
    endcase
  end

  // effective grid size, clamped into 1..MAX
  logic [DIM_W-1:0] r_eff, c_eff;

  always_comb begin
    if (row_count == 6'd0) r_eff = DIM_W'(1);
    else if (DIM_W'(row_count) > DIM_W'(MAX_ROWS)) r_eff = DIM_W'(MAX_ROWS);
    else r_eff = DIM_W'(row_count);
    if (col_count == 8'd0) c_eff = DIM_W'(1);
    else if (DIM_W'(col_count) > DIM_W'(MAX_COLS)) c_eff = DIM_W'(MAX_COLS);
    else c_eff = DIM_W'(col_count);
  end

  // --------------------------------------------------------------------------
  // control state
  // --------------------------------------------------------------------------
  state_t            state;
  logic              phase_cur;     // 1: reading around the current cell
  logic [1:0]        rd_cnt;
  logic [ROW_AW-1:0] cr;            // center of the read sweep
  logic [COL_AW-1:0] cc;
  logic [ROW_AW-1:0] cur_row;
  logic [COL_AW-1:0] cur_col;
  logic [CNT_W-1:0]  cells_left;
  logic [5:0]        pick_row_q;
  logic [7:0]        pick_col_q;
  logic [6:0]        draw_q;

  // neighbour bits of the center, already masked by row valid
  logic nb_up, nb_down, nb_left, nb_right, nb_self;

  // pending result
  status_t    res_status;
  logic [5:0] res_from_row;
  logic [7:0] res_from_col;
  dir_t       res_dir;

  // output register
  logic       out_valid;
  status_t    out_status;
  logic [5:0] out_from_row;
  logic [7:0] out_from_col;
  dir_t       out_dir;
  logic       out_complete;

  logic s_acc, start_acc;
  assign s_tready  = (state == S_IDLE);
  assign s_acc     = s_tvalid && s_tready;
  assign start_acc = s_acc && (s_tuser == FUNC_START);

  // pick source: live fields while idle, captured copy afterwards
  logic [5:0]        pk_row;
  logic [7:0]        pk_col;
  logic              pick_in_grid;
  logic [ROW_AW-1:0] pk_r0;
  logic [COL_AW-1:0] pk_c0;

  assign pk_row = (state == S_IDLE) ? s_tdata[5:0] : pick_row_q;
  assign pk_col = (state == S_IDLE) ? s_tdata[13:6] : pick_col_q;
  assign pick_in_grid = (pk_row != 6'd0) && (DIM_W'(pk_row) <= r_eff) &&
                        (pk_col != 8'd0) && (DIM_W'(pk_col) <= c_eff);
  assign pk_r0 = ROW_AW'(DIM_W'(pk_row) - DIM_W'(1));
  assign pk_c0 = COL_AW'(DIM_W'(pk_col) - DIM_W'(1));

  logic cur_in_grid;
  assign cur_in_grid = (DIM_W'(cur_row) < r_eff) && (DIM_W'(cur_col) < c_eff);

  // neighbour geometry of the center
  logic              up_in, down_in, left_in, right_in;
  logic [ROW_AW-1:0] row_up, row_dn;
  logic [COL_AW-1:0] col_l, col_r;

  assign up_in    = (cr != '0);
  assign down_in  = (DIM_W'(cr) + DIM_W'(1)) < r_eff;
  assign left_in  = (cc != '0);
  assign right_in = (DIM_W'(cc) + DIM_W'(1)) < c_eff;
  // out-of-grid neighbours fall back to the center so addresses stay in range
  assign row_up   = up_in    ? cr - ROW_AW'(1) : cr;
  assign row_dn   = down_in  ? cr + ROW_AW'(1) : cr;
  assign col_l    = left_in  ? cc - COL_AW'(1) : cc;
  assign col_r    = right_in ? cc + COL_AW'(1) : cc;

  // --------------------------------------------------------------------------
  // visited map: row-wide RAM plus per-row valid flops
  // --------------------------------------------------------------------------
  logic [MAX_COLS-1:0] vmap [MAX_ROWS];
  logic [MAX_ROWS-1:0] row_valid;
  logic [ROW_AW-1:0]   rd_addr;
  logic [MAX_COLS-1:0] rd_row;
  logic                rd_vld;
  logic [MAX_COLS-1:0] row_eff;
  logic                mem_we;
  logic [ROW_AW-1:0]   wr_row;
  logic [COL_AW-1:0]   wr_col;
  logic [MAX_COLS-1:0] wr_onehot, wr_mask;

  always_comb begin
    case (rd_cnt)
      2'd0:    rd_addr = row_up;
      2'd1:    rd_addr = cr;
      default: rd_addr = row_dn;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      for (int i = 0; i < MAX_COLS; i++) begin
        if (wr_mask[i]) vmap[wr_row][i] <= wr_onehot[i];
      end
    end
    rd_row <= vmap[rd_addr];
    rd_vld <= row_valid[rd_addr];
  end

  assign row_eff = rd_row & {MAX_COLS{rd_vld}};

  // --------------------------------------------------------------------------
  // evaluate: base check and carve target
  // --------------------------------------------------------------------------
  logic              stuck, base_ok, carve_go;
  dir_t              d;
  logic              tgt_in, tgt_vis;
  logic [ROW_AW-1:0] tgt_row;
  logic [COL_AW-1:0] tgt_col;

  assign stuck = !((up_in && !nb_up) || (down_in && !nb_down) ||
                   (left_in && !nb_left) || (right_in && !nb_right));
  assign base_ok = phase_cur ? !stuck : nb_self;
  assign d = draw_to_dir(draw_q);

  always_comb begin
    case (d)
      DIR_RIGHT: begin
        tgt_in = right_in; tgt_vis = nb_right; tgt_row = cr; tgt_col = col_r;
      end
      DIR_LEFT: begin
        tgt_in = left_in; tgt_vis = nb_left; tgt_row = cr; tgt_col = col_l;
      end
      DIR_DOWN: begin
        tgt_in = down_in; tgt_vis = nb_down; tgt_row = row_dn; tgt_col = cc;
      end
      default: begin
        tgt_in = up_in; tgt_vis = nb_up; tgt_row = row_up; tgt_col = cc;
      end
    endcase
  end

  assign carve_go = (state == S_EVAL) && base_ok && tgt_in && !tgt_vis;

  // write port: start marks the far corner, a carve marks its target
  assign mem_we    = start_acc || carve_go;
  assign wr_row    = start_acc ? ROW_AW'(r_eff - DIM_W'(1)) : tgt_row;
  assign wr_col    = start_acc ? COL_AW'(c_eff - DIM_W'(1)) : tgt_col;
  assign wr_onehot = MAX_COLS'(1) << wr_col;
  // a stale row (invalid, or any row at start) is rewritten whole
  assign wr_mask   = (row_valid[wr_row] && !start_acc) ? wr_onehot : '1;

  // --------------------------------------------------------------------------
  // sequencer
  // --------------------------------------------------------------------------
  logic [2*DIM_W-1:0] area;
  assign area = r_eff * c_eff;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      phase_cur  <= 1'b0;
      rd_cnt     <= 2'd0;
      cur_row    <= '0;
      cur_col    <= '0;
      cells_left <= '0;
      row_valid  <= '0;
      out_valid  <= 1'b0;
    end else begin
      // the result cycle reloads the register itself
      if (out_valid && m_tready && (state != S_FIN)) out_valid <= 1'b0;

      case (state)
        S_IDLE: begin
          if (s_acc) begin
            pick_row_q   <= s_tdata[5:0];
            pick_col_q   <= s_tdata[13:6];
            draw_q       <= s_tdata[20:14];
            res_from_row <= 6'd0;
            res_from_col <= 8'd0;
            res_dir      <= DIR_RIGHT;
            rd_cnt       <= 2'd0;
            if (s_tuser == FUNC_START) begin
              for (int i = 0; i < MAX_ROWS; i++) begin
                row_valid[i] <= (ROW_AW'(i) == wr_row);
              end
              cur_row    <= wr_row;
              cur_col    <= wr_col;
              cells_left <= CNT_W'(area - (2*DIM_W)'(1));
              res_status <= ST_STARTED;
              state      <= S_FIN;
            end else if (cells_left == '0) begin
              res_status <= ST_FULL;
              state      <= S_FIN;
            end else if (walk_mode && cur_in_grid) begin
              cr        <= cur_row;
              cc        <= cur_col;
              phase_cur <= 1'b1;
              state     <= S_READ;
            end else if (pick_in_grid) begin
              cr        <= pk_r0;
              cc        <= pk_c0;
              phase_cur <= 1'b0;
              state     <= S_READ;
            end else begin
              res_status <= ST_REJECTED;
              state      <= S_FIN;
            end
          end
        end

        S_READ: begin
          // row data comes from the registered read of the previous address
          case (rd_cnt)
            2'd1: nb_up <= row_eff[cc];
            2'd2: begin
              nb_left  <= row_eff[col_l];
              nb_self  <= row_eff[cc];
              nb_right <= row_eff[col_r];
            end
            2'd3: nb_down <= row_eff[cc];
            default: ;
          endcase
          rd_cnt <= rd_cnt + 2'd1;
          if (rd_cnt == 2'd3) state <= S_EVAL;
        end

        S_EVAL: begin
          rd_cnt <= 2'd0;
          if (phase_cur && stuck) begin
            // current cell has nowhere to go: fall back to the pick
            if (pick_in_grid) begin
              cr        <= pk_r0;
              cc        <= pk_c0;
              phase_cur <= 1'b0;
              state     <= S_READ;
            end else begin
              res_status <= ST_REJECTED;
              state      <= S_FIN;
            end
          end else if (!base_ok) begin
            res_status <= ST_REJECTED;
            state      <= S_FIN;
          end else begin
            // a valid pick becomes current in walk mode even if the carve fails
            if (!phase_cur && walk_mode && !carve_go) begin
              cur_row <= cr;
              cur_col <= cc;
            end
            if (carve_go) begin
              row_valid[tgt_row] <= 1'b1;
              cells_left   <= cells_left - CNT_W'(1);
              res_status   <= ST_CARVED;
              res_from_row <= 6'(DIM_W'(cr) + DIM_W'(1));
              res_from_col <= 8'(DIM_W'(cc) + DIM_W'(1));
              res_dir      <= d;
              if (walk_mode) begin
                cur_row <= tgt_row;
                cur_col <= tgt_col;
              end
            end else begin
              res_status <= ST_REJECTED;
            end
            state <= S_FIN;
          end
        end

        S_FIN: begin
          if (!out_valid || m_tready) begin
            out_valid    <= 1'b1;
            out_status   <= res_status;
            out_from_row <= res_from_row;
            out_from_col <= res_from_col;
            out_dir      <= res_dir;
            out_complete <= (cells_left == '0);
            state        <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

  assign m_tvalid = out_valid;
  assign m_tuser  = out_status;
  assign m_tdata  = {7'd0, out_complete, out_dir, out_from_col, out_from_row};

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  logic rd_oob, full_no_flag;
  assign rd_oob       = DIM_W'(rd_addr) >= DIM_W'(MAX_ROWS);
  assign full_no_flag = out_valid && (out_status == ST_FULL) && !out_complete;

  `RMC_ASSERT(a_left_mono, clk, rst, !start_acc |=> cells_left <= $past(cells_left), "count rose")
  `RMC_NEVER(a_carve_nonzero, clk, rst, carve_go && (cells_left == '0), "carve at zero count")
  `RMC_NEVER(a_rd_range, clk, rst, (state == S_READ) && rd_oob, "row read out of range")
  `RMC_NEVER(a_full_flag, clk, rst, full_no_flag, "complete status without complete flag")

endmodule

/* bench/random_maze_carver_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// random_maze_carver_tb
// Self-checking bench for the maze carver: a directed pass over the corner
// cases, then random maze growth under several flow-control patterns.
// Every accepted input runs through a local predictor of the visited map and
// the walk state. Every output transaction is checked field by field against
// the oldest expected result.
// ----------------------------------------------------------------------------
module random_maze_carver_tb;
  import rmc_pkg::*;

  localparam int CLK_PERIOD  = 10;
  localparam int CYCLE_LIMIT = 300000;
  localparam int TAIL_CYCLES = 20;
  localparam int MAX_SHOWN   = 30;
  localparam int HOLD_CYCLES = 80;
  localparam int GRID_ROWS   = DEF_MAX_ROWS;
  localparam int GRID_COLS   = DEF_MAX_COLS;
  // register values after reset
  localparam int  ROWS_AT_RESET = 9;
  localparam int  COLS_AT_RESET = 9;
  localparam bit  WALK_AT_RESET = 1'b0;
  localparam logic FUNC_ATTEMPT = ~FUNC_START;

  // one expected output transaction
  typedef struct {
    status_t    status;
    logic [5:0] from_row;
    logic [7:0] from_col;
    dir_t       dir;
    logic       complete;
  } carve_result_t;

  logic                 clk      = 1'b0;
  logic                 rst      = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [23:0]          s_tdata  = '0;   // pick_row[5:0], pick_col[13:6], dir_draw[20:14]
  logic                 s_tuser  = 1'b0; // func
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [23:0]          m_tdata;         // from_row[5:0], from_col[13:6], carve_dir[15:14],
                                         // complete[16]
  logic [STATUS_W-1:0]  m_tuser;         // status
  logic                 psel     = 1'b0;
  logic                 penable  = 1'b0;
  logic                 pwrite   = 1'b0;
  logic [ADDR_W-1:0]    paddr    = '0;
  logic [31:0]          pwdata   = '0;
  logic [31:0]          prdata;
  logic                 pready;

  random_maze_carver DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // --------------------------------------------------------------------------
  // Predictor state: visited map, walk position, cells still unreached and a
  // copy of the three registers. Visited cells are also kept as a list of
  // 1-based coordinates so the stimulus can pick good base cells.
  // --------------------------------------------------------------------------
  bit  visited [GRID_ROWS][GRID_COLS];
  int  cur_r, cur_c, cells_left;
  int  rows_reg = ROWS_AT_RESET;
  int  cols_reg = COLS_AT_RESET;
  bit  walk_reg = WALK_AT_RESET;
  int  visited_rows[$];
  int  visited_cols[$];

  carve_result_t pending_results[$];

  int errors, cycle_count, items_sent;
  int carves, rejects, full_hits, mazes_done;
  int send_idle_pct, recv_stall_pct;
  int hold_request, hold_left;

  initial forever #(CLK_PERIOD / 2) clk = ~clk;

  // Register values out of range are clamped where they are used.
  function automatic int grid_rows();
    if (rows_reg < 1) return 1;
    if (rows_reg > GRID_ROWS) return GRID_ROWS;
    return rows_reg;
  endfunction

  function automatic int grid_cols();
    if (cols_reg < 1) return 1;
    if (cols_reg > GRID_COLS) return GRID_COLS;
    return cols_reg;
  endfunction

  // 0-based neighbor of (r, c); returns 0 when it falls off the grid
  function automatic bit neighbor_cell(int r, int c, dir_t d, int nrows, int ncols,
                                       output int nr, output int nc);
    nr = r;
    nc = c;
    case (d)
      DIR_RIGHT: begin
        if (c + 1 >= ncols) return 1'b0;
        nc = c + 1;
      end
      DIR_LEFT: begin
        if (c == 0) return 1'b0;
        nc = c - 1;
      end
      DIR_DOWN: begin
        if (r + 1 >= nrows) return 1'b0;
        nr = r + 1;
      end
      default: begin
        if (r == 0) return 1'b0;
        nr = r - 1;
      end
    endcase
    return 1'b1;
  endfunction

  // A cell off the grid counts as stuck, so walk mode falls back to the pick.
  function automatic bit cell_stuck(int r, int c, int nrows, int ncols);
    int nr, nc;
    if (r >= nrows || c >= ncols) return 1'b1;
    for (int d = 0; d < 4; d++) begin
      if (neighbor_cell(r, c, dir_t'(d), nrows, ncols, nr, nc)) begin
        if (!visited[nr][nc]) return 1'b0;
      end
    end
    return 1'b1;
  endfunction

  function automatic bit pick_usable(int pr, int pc, int nrows, int ncols);
    if (pr < 1 || pr > nrows || pc < 1 || pc > ncols) return 1'b0;
    return visited[pr - 1][pc - 1];
  endfunction

  function automatic void mark_visited(int r, int c);
    visited[r][c] = 1'b1;
    visited_rows.push_back(r + 1);
    visited_cols.push_back(c + 1);
  endfunction

  // Works out the result of one input transaction and advances the state.
  function automatic carve_result_t predict_carve(logic fn, logic [5:0] pr,
                                                  logic [7:0] pc, logic [6:0] draw);
    carve_result_t res;
    int   nrows, ncols, br, bc, nr, nc;
    bit   have_base;
    dir_t d;
    nrows        = grid_rows();
    ncols        = grid_cols();
    res.status   = ST_REJECTED;
    res.from_row = '0;
    res.from_col = '0;
    res.dir      = DIR_RIGHT;
    have_base    = 1'b0;
    br           = 0;
    bc           = 0;
    if (fn == FUNC_START) begin
      visited = '{default: 1'b0};
      visited_rows.delete();
      visited_cols.delete();
      cur_r = nrows - 1;
      cur_c = ncols - 1;
      mark_visited(cur_r, cur_c);
      cells_left = nrows * ncols - 1;
      res.status = ST_STARTED;
    end else if (cells_left == 0) begin
      res.status = ST_FULL;
    end else begin
      if (walk_reg && !cell_stuck(cur_r, cur_c, nrows, ncols)) begin
        br        = cur_r;
        bc        = cur_c;
        have_base = 1'b1;
      end else if (pick_usable(int'(pr), int'(pc), nrows, ncols)) begin
        br        = int'(pr) - 1;
        bc        = int'(pc) - 1;
        have_base = 1'b1;
        // a good pick moves the walker even if the carve then fails
        if (walk_reg) begin
          cur_r = br;
          cur_c = bc;
        end
      end
      if (have_base) begin
        if (draw < DRAW_RIGHT_BELOW) d = DIR_RIGHT;
        else if (draw < DRAW_LEFT_BELOW) d = DIR_LEFT;
        else if (draw < DRAW_DOWN_BELOW) d = DIR_DOWN;
        else d = DIR_UP;
        if (neighbor_cell(br, bc, d, nrows, ncols, nr, nc)) begin
          if (!visited[nr][nc]) begin
            mark_visited(nr, nc);
            cells_left--;
            res.status   = ST_CARVED;
            res.from_row = 6'(br + 1);
            res.from_col = 8'(bc + 1);
            res.dir      = d;
            if (walk_reg) begin
              cur_r = nr;
              cur_c = nc;
            end
          end
        end
      end
    end
    res.complete = (cells_left == 0);
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Input side. Optional idle cycles first, then the item is held until the
  // handshake; the expectation is formed at the accepting edge. valid is left
  // high afterwards so back-to-back items never toggle it within one step.
  // --------------------------------------------------------------------------
  task automatic send_item(logic fn, logic [5:0] pr, logic [7:0] pc, logic [6:0] draw);
    carve_result_t res;
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
    end
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tuser  <= fn;
    s_tdata  <= {3'b000, draw, pc, pr};
    do @(posedge clk); while (!s_tready);
    res = predict_carve(fn, pr, pc, draw);
    pending_results.push_back(res);
    items_sent++;
    case (res.status)
      ST_CARVED:   carves++;
      ST_REJECTED: rejects++;
      ST_FULL:     full_hits++;
      default:     ;
    endcase
    if (res.status == ST_CARVED && res.complete) mazes_done++;
  endtask

  // Sender pauses until every expected result has been taken.
  task automatic wait_for_results();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // One APB transfer: setup cycle, access cycle, done at the pready edge.
  task automatic apb_access(logic [1:0] idx, logic wr, logic [31:0] value,
                            output logic [31:0] rd);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rd = prdata;
  endtask

  function automatic void check_field(string what, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      errors++;
      if (errors <= MAX_SHOWN)
        $display("%0t ERROR %s: expected %0d, actual %0d", $time, what, want, got);
    end
  endfunction

  // Grid size and mode are only changed with nothing in flight.
  task automatic set_config(int rows, int cols, bit walk);
    logic [31:0] rd;
    wait_for_results();
    apb_access(REG_ROWS, 1'b1, rows, rd);
    rows_reg = rows & 'h3F;
    apb_access(REG_COLS, 1'b1, cols, rd);
    cols_reg = cols & 'hFF;
    apb_access(REG_WALK, 1'b1, 32'(walk), rd);
    walk_reg = walk;
    apb_access(REG_ROWS, 1'b0, '0, rd);
    check_field("row_count readback", rows_reg, 32'(rd[5:0]));
    apb_access(REG_COLS, 1'b0, '0, rd);
    check_field("col_count readback", cols_reg, 32'(rd[7:0]));
    apb_access(REG_WALK, 1'b0, '0, rd);
    check_field("walk_mode readback", 32'(walk_reg), 32'(rd[0]));
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Output side: random back-pressure plus an optional long hold-off that a
  // test requests and this process counts down.
  // --------------------------------------------------------------------------
  initial forever begin
    @(negedge clk);
    if (hold_request > 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Result checker: every output transaction against the oldest expectation.
  always @(posedge clk) begin : result_check
    carve_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        errors++;
        if (errors <= MAX_SHOWN)
          $display("%0t ERROR unexpected result: expected none, actual status %0d",
                   $time, m_tuser);
      end else begin
        want = pending_results.pop_front();
        check_field("status", 32'(want.status), 32'(m_tuser));
        check_field("from_row", 32'(want.from_row), 32'(m_tdata[5:0]));
        check_field("from_col", 32'(want.from_col), 32'(m_tdata[13:6]));
        check_field("carve_dir", 32'(want.dir), 32'(m_tdata[15:14]));
        check_field("complete", 32'(want.complete), 32'(m_tdata[16]));
      end
    end
  end

  // Watchdog on total run length.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t timeout with %0d results outstanding", $time, pending_results.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // No start yet: the count is zero, so attempts report a finished maze.
  // Also the top and bottom codes of every input field.
  task automatic test_attempt_before_start();
    send_item(FUNC_ATTEMPT, 6'd63, 8'd255, 7'd127);
    send_item(FUNC_ATTEMPT, 6'd0, 8'd0, 7'd0);
  endtask

  // Zero sizes clamp to a single cell (complete right after start); oversize
  // values clamp to the full grid.
  task automatic test_register_clamp();
    set_config(0, 0, 1'b0);
    send_item(FUNC_START, 6'd1, 8'd1, 7'd0);
    send_item(FUNC_ATTEMPT, 6'd1, 8'd1, 7'd99);
    set_config(63, 255, 1'b0);
    send_item(FUNC_START, 6'd0, 8'd0, 7'd0);
    send_item(FUNC_ATTEMPT, 6'd32, 8'd128, 7'd0);   // right edge of the grid
    send_item(FUNC_ATTEMPT, 6'd32, 8'd128, 7'd99);  // up from the far corner
    send_item(FUNC_ATTEMPT, 6'd0, 8'd0, 7'd50);     // pick off the grid
  endtask

  // Free mode: unvisited pick, direction band edges, draw above 99.
  task automatic test_free_mode();
    set_config(3, 4, 1'b0);
    send_item(FUNC_START, 6'd0, 8'd0, 7'd0);
    send_item(FUNC_ATTEMPT, 6'd1, 8'd1, 7'd60);
    send_item(FUNC_ATTEMPT, 6'd3, 8'd4, 7'd25);
    send_item(FUNC_ATTEMPT, 6'd3, 8'd4, 7'd74);
    send_item(FUNC_ATTEMPT, 6'd3, 8'd3, 7'd100);
  endtask

  // Walk mode on a 2x3 grid: walk into a dead end, reject a bad pick, take a
  // good pick whose carve fails (walker still moves), carve from there, then
  // shrink the grid so the walker sits outside it and the pick is used.
  task automatic test_walk_mode();
    set_config(2, 3, 1'b1);
    send_item(FUNC_START, 6'd0, 8'd0, 7'd0);
    send_item(FUNC_ATTEMPT, 6'd0, 8'd0, 7'd30);
    send_item(FUNC_ATTEMPT, 6'd0, 8'd0, 7'd80);
    send_item(FUNC_ATTEMPT, 6'd0, 8'd0, 7'd0);
    send_item(FUNC_ATTEMPT, 6'd1, 8'd1, 7'd0);
    send_item(FUNC_ATTEMPT, 6'd2, 8'd2, 7'd80);
    send_item(FUNC_ATTEMPT, 6'd0, 8'd0, 7'd30);
    set_config(1, 3, 1'b1);
    send_item(FUNC_ATTEMPT, 6'd1, 8'd2, 7'd30);
  endtask

  // Random mazes: mostly small grids grown to completion from good picks,
  // with noise picks, stray starts and out-of-band draws mixed in.
  task automatic test_random_phase(int n_items, int send_pct, int recv_pct, bit pressure);
    int         sent_here, budget, kind, rows, cols, k;
    bit         held, paused;
    logic       fn;
    logic [5:0] pr;
    logic [7:0] pc;
    logic [6:0] draw;
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    sent_here      = 0;
    held           = 1'b0;
    paused         = 1'b0;
    while (sent_here < n_items) begin
      kind = $urandom_range(99);
      if (kind < 75) begin
        rows = $urandom_range(1, 6);
        cols = $urandom_range(1, 10);
      end else if (kind < 90) begin
        rows = $urandom_range(1, 32);
        cols = $urandom_range(1, 40);
      end else begin
        case ($urandom_range(3))
          0:       rows = 0;
          1:       rows = 1;
          2:       rows = 32;
          default: rows = 63;
        endcase
        case ($urandom_range(3))
          0:       cols = 0;
          1:       cols = 1;
          2:       cols = 128;
          default: cols = 255;
        endcase
      end
      set_config(rows, cols, 1'($urandom_range(1)));
      send_item(FUNC_START, 6'($urandom_range(63)), 8'($urandom_range(255)),
                7'($urandom_range(127)));
      sent_here++;
      budget = grid_rows() * grid_cols() * 4 + 6;
      if (budget > 120) budget = 120;
      while (budget > 0 && sent_here < n_items) begin
        // long receiver hold-off while the sender keeps offering
        if (pressure && !held && sent_here >= n_items / 2) begin
          hold_request = HOLD_CYCLES;
          held         = 1'b1;
        end
        if (!paused && sent_here >= (n_items * 3) / 4) begin
          wait_for_results();
          paused = 1'b1;
        end
        // a couple of attempts past completion, then a new maze
        if (cells_left == 0 && budget > 2) budget = 2;
        kind = $urandom_range(99);
        fn   = (kind < 3) ? FUNC_START : FUNC_ATTEMPT;
        if (kind < 20 || visited_rows.size() == 0) begin
          pr = 6'($urandom_range(63));
          pc = 8'($urandom_range(255));
        end else begin
          k  = $urandom_range(visited_rows.size() - 1);
          pr = 6'(visited_rows[k]);
          pc = 8'(visited_cols[k]);
        end
        draw = ($urandom_range(9) == 0) ? 7'($urandom_range(127)) : 7'($urandom_range(99));
        send_item(fn, pr, pc, draw);
        sent_here++;
        budget--;
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_attempt_before_start();
    test_register_clamp();
    test_free_mode();
    test_walk_mode();
    test_random_phase(220, 0, 0, 1'b0);    // full rate both sides
    test_random_phase(220, 56, 0, 1'b0);   // sender gaps
    test_random_phase(220, 0, 56, 1'b1);   // receiver stalls, long hold-off
    test_random_phase(220, 21, 21, 1'b1);  // both sides

    wait_for_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Run covered %0d transactions: %0d carves, %0d rejects, %0d past completion,",
             items_sent, carves, rejects, full_hits);
    $display("%0d mazes grown to completion, free and walk modes, %0d mismatches.",
             mazes_done, errors);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+hdl
hdl/rmc_pkg.sv
hdl/random_maze_carver.sv
bench/random_maze_carver_tb.sv
